/* hdl/rcm_pkg.sv */
package rcm_pkg;

	// bank index: RAM banks 0..2, ROM as 3
	typedef logic [1:0] bank_t;
	typedef logic [2:0] map_sel_t;

	localparam bank_t ROM_BANK = 2'd3;

	// lower and upper half mapping per map select
	localparam bank_t LOWER_BANK [8] = '{2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1};
	localparam bank_t UPPER_BANK [8] = '{2'd3, 2'd3, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2};

	// hotspots and timing
	localparam logic [11:0] CFG_ADDR    = 12'hFF8;
	localparam logic [11:0] LOAD_ADDR   = 12'h850;
	localparam logic [31:0] WRITE_DELAY = 32'd5;

	// configuration byte fields
	localparam int CFG_WE_BIT  = 1;
	localparam int CFG_MAP_LSB = 2;

	// boot ROM fill values
	localparam logic [7:0] ROM_FILL   = 8'h02;
	localparam logic [7:0] VEC_LO     = 8'h0A;
	localparam logic [7:0] VEC_HI     = 8'hF8;
	localparam int         VEC_BYTES  = 4;

	localparam int BOOT_LEN = 289;
	localparam logic [7:0] BOOT_IMAGE [BOOT_LEN] = '{
		8'ha5, 8'hfa, 8'h85, 8'h80, 8'h4c, 8'h18, 8'hf8, 8'hff, 8'hff, 8'hff, 8'h78, 8'hd8,
		8'ha0, 8'h00, 8'ha2, 8'h00, 8'h94, 8'h00, 8'he8, 8'hd0, 8'hfb, 8'h4c, 8'h50, 8'hf8,
		8'ha2, 8'h00, 8'hbd, 8'h06, 8'hf0, 8'had, 8'hf8, 8'hff, 8'ha2, 8'h00, 8'had, 8'h00,
		8'hf0, 8'hea, 8'hbd, 8'h00, 8'hf7, 8'hca, 8'hd0, 8'hf6, 8'h4c, 8'h50, 8'hf8, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'ha2, 8'h03, 8'hbc, 8'h1d,
		8'hf9, 8'h94, 8'hfa, 8'hca, 8'h10, 8'hf8, 8'ha0, 8'h00, 8'ha2, 8'h28, 8'h94, 8'h04,
		8'hca, 8'h10, 8'hfb, 8'ha2, 8'h1c, 8'h94, 8'h81, 8'hca, 8'h10, 8'hfb, 8'ha9, 8'h00,
		8'h85, 8'h1b, 8'h85, 8'h1c, 8'h85, 8'h1d, 8'h85, 8'h1e, 8'h85, 8'h1f, 8'h85, 8'h19,
		8'h85, 8'h1a, 8'h85, 8'h08, 8'h85, 8'h01, 8'ha9, 8'h10, 8'h85, 8'h21, 8'h85, 8'h02,
		8'ha2, 8'h07, 8'hca, 8'hca, 8'hd0, 8'hfd, 8'ha9, 8'h00, 8'h85, 8'h20, 8'h85, 8'h10,
		8'h85, 8'h11, 8'h85, 8'h02, 8'h85, 8'h2a, 8'ha9, 8'h05, 8'h85, 8'h0a, 8'ha9, 8'hff,
		8'h85, 8'h0d, 8'h85, 8'h0e, 8'h85, 8'h0f, 8'h85, 8'h84, 8'h85, 8'h85, 8'ha9, 8'hf0,
		8'h85, 8'h83, 8'ha9, 8'h74, 8'h85, 8'h09, 8'ha9, 8'h0c, 8'h85, 8'h15, 8'ha9, 8'h1f,
		8'h85, 8'h17, 8'h85, 8'h82, 8'ha9, 8'h07, 8'h85, 8'h19, 8'ha2, 8'h08, 8'ha0, 8'h00,
		8'h85, 8'h02, 8'h88, 8'hd0, 8'hfb, 8'h85, 8'h02, 8'h85, 8'h02, 8'ha9, 8'h02, 8'h85,
		8'h02, 8'h85, 8'h00, 8'h85, 8'h02, 8'h85, 8'h02, 8'h85, 8'h02, 8'ha9, 8'h00, 8'h85,
		8'h00, 8'hca, 8'h10, 8'he4, 8'h06, 8'h83, 8'h66, 8'h84, 8'h26, 8'h85, 8'ha5, 8'h83,
		8'h85, 8'h0d, 8'ha5, 8'h84, 8'h85, 8'h0e, 8'ha5, 8'h85, 8'h85, 8'h0f, 8'ha6, 8'h82,
		8'hca, 8'h86, 8'h82, 8'h86, 8'h17, 8'he0, 8'h0a, 8'hd0, 8'hc3, 8'ha9, 8'h02, 8'h85,
		8'h01, 8'ha2, 8'h1c, 8'ha0, 8'h00, 8'h84, 8'h19, 8'h84, 8'h09, 8'h94, 8'h81, 8'hca,
		8'h10, 8'hfb, 8'ha6, 8'h80, 8'hdd, 8'h00, 8'hf0, 8'ha5, 8'h80, 8'h45, 8'hfe, 8'h45,
		8'hff, 8'ha2, 8'hff, 8'ha0, 8'h00, 8'h9a, 8'h4c, 8'hfa, 8'h00, 8'hcd, 8'hf8, 8'hff,
		8'h4c
	};

	// boot ROM contents: image, then fill, last four bytes are the vectors
	function automatic logic [7:0] boot_byte(input int unsigned idx, input int unsigned depth);
		int unsigned k;
		k = idx + VEC_BYTES - depth;
		if (idx + VEC_BYTES >= depth)
			return k[0] ? VEC_HI : VEC_LO;
		else if (idx < BOOT_LEN)
			return BOOT_IMAGE[idx];
		else
			return ROM_FILL;
	endfunction

	function automatic logic rom_mapped(input map_sel_t sel);
		return UPPER_BANK[sel] == ROM_BANK;
	endfunction

endpackage

/* hdl/rcm_store.sv */
module rcm_store import rcm_pkg::*; #(
	parameter int BANK_BYTES = 2048,
	parameter int RAM_BANKS  = 3,
	localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES,
	localparam int AW        = $clog2(RAM_DEPTH),
	localparam int OFF_W     = $clog2(BANK_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             busy,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic [OFF_W-1:0] rom_addr,
	output logic [7:0]       ram_q,
	output logic [7:0]       rom_q
);

	logic [7:0]    mem [RAM_DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;

	// clearing pass after reset, one byte a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == AW'(RAM_DEPTH - 1))
				busy_q <= 1'b0;
			else
				clr_q <= clr_q + AW'(1);
		end
	end

	assign busy = busy_q;

	// RAM write port
	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= 8'h00;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ram_q <= mem[rd_addr];
			rom_q <= boot_byte(int'(rom_addr), BANK_BYTES);
		end
	end

endmodule

/* hdl/ram_cart_mapper_delayed_write_top.sv */
// Cartridge bus mapper: three RAM banks of BANK_BYTES and a boot ROM behind a 4 KB window.
// Each item is one bus access; one result item comes back per access, via the read stage
// and the output register. The bank store is a single synchronous RAM, read once and
// written at most once per access, so a new item is taken every cycle unless stalled;
// s_axis_tready falls when both the read stage and the output register hold items that
// the sink has not taken, and during the clearing sweep. After reset the RAM is swept
// to zero, one byte a cycle, over RAM_BANKS*BANK_BYTES bytes (6144 at the defaults).
module ram_cart_mapper_delayed_write_top import rcm_pkg::*; #(
	parameter int BANK_BYTES = 2048,
	parameter int RAM_BANKS  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [11:0] address, [43:12] distinct_count
	input  logic        s_axis_tuser,  // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] load_request
);

	localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int OFF_W     = $clog2(BANK_BYTES);

	// mapper state
	logic [7:0]  hold_q;
	logic        armed_q;
	logic [31:0] deadline_q;
	logic        writable_q;
	map_sel_t    map_q;

	// read stage and output register
	logic        v_s1, write_s1, fwd_s1, rom_s1, req_s1;
	logic [7:0]  hold_s1;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_req_q;

	logic        busy, accept, advance;
	logic [7:0]  ram_q, rom_q;

	// input fields
	logic        is_write, hi, low_page, cfg_hit, ld_hit;
	logic [11:0] addr;
	logic [31:0] cnt, diff;
	logic        expire, armed_e, do_arm, do_cfg, due, wr_go;
	logic        armed_n, writable_n;
	map_sel_t    map_n;
	bank_t       bank;
	logic [OFF_W-1:0] off;
	logic [AW-1:0]    ram_addr;
	logic        rd_rom;

	// offset within a half, modulo the bank size
	function automatic logic [OFF_W-1:0] bank_off(input logic [10:0] a);
		logic [13:0] r;
		r = {3'b000, a};
		if (r >= 14'(BANK_BYTES * 4))
			r = r - 14'(BANK_BYTES * 4);
		if (r >= 14'(BANK_BYTES * 2))
			r = r - 14'(BANK_BYTES * 2);
		if (r >= 14'(BANK_BYTES))
			r = r - 14'(BANK_BYTES);
		return r[OFF_W-1:0];
	endfunction

	assign is_write = s_axis_tuser;
	assign addr     = s_axis_tdata[11:0];
	assign cnt      = s_axis_tdata[43:12];
	assign hi       = addr[11];
	assign low_page = addr[11:8] == 4'h0;
	assign cfg_hit  = addr == CFG_ADDR;
	assign ld_hit   = !is_write && addr == LOAD_ADDR && rom_mapped(map_q);

	// load hit first, then expiry, then arm / configure / due write, in that priority
	always_comb begin
		diff    = cnt - deadline_q;
		expire  = armed_q && diff != 32'd0 && !diff[31];
		armed_e = ld_hit ? armed_q : (armed_q && !expire);
		do_arm  = !ld_hit && low_page && (!writable_q || !armed_e);
		do_cfg  = !ld_hit && !do_arm && cfg_hit;
		due     = !ld_hit && !do_arm && !cfg_hit && armed_e && writable_q
		          && cnt == deadline_q;
		wr_go   = due && !(hi && rom_mapped(map_q));
		if (do_arm)
			armed_n = 1'b1;
		else if (do_cfg || due)
			armed_n = 1'b0;
		else
			armed_n = armed_e;
		map_n      = do_cfg ? hold_q[CFG_MAP_LSB +: 3] : map_q;
		writable_n = do_cfg ? hold_q[CFG_WE_BIT] : writable_q;
	end

	// location through the (possibly new) mapping
	always_comb begin
		off    = bank_off(addr[10:0]);
		bank   = hi ? UPPER_BANK[map_n] : LOWER_BANK[map_n];
		rd_rom = hi && bank == ROM_BANK;
		case (bank)
			2'd0:    ram_addr = AW'(off);
			2'd1:    ram_addr = AW'(off) + AW'(BANK_BYTES);
			default: ram_addr = AW'(off) + AW'(2 * BANK_BYTES);
		endcase
	end

	// handshake
	assign advance       = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !busy && (!v_s1 || !out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	rcm_store #(
		.BANK_BYTES (BANK_BYTES),
		.RAM_BANKS  (RAM_BANKS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.busy     (busy),
		.wr_en    (accept && wr_go),
		.wr_addr  (ram_addr),
		.wr_data  (hold_q),
		.rd_en    (accept),
		.rd_addr  (ram_addr),
		.rom_addr (off),
		.ram_q    (ram_q),
		.rom_q    (rom_q)
	);

	// mapper state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q     <= 8'h00;
			armed_q    <= 1'b0;
			deadline_q <= WRITE_DELAY;
			writable_q <= 1'b0;
			map_q      <= '0;
		end else if (accept) begin
			armed_q    <= armed_n;
			writable_q <= writable_n;
			map_q      <= map_n;
			if (do_arm) begin
				hold_q     <= addr[7:0];
				deadline_q <= cnt + WRITE_DELAY;
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (advance)
			v_s1 <= 1'b0;
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1 <= is_write;
			fwd_s1   <= wr_go && !is_write;
			rom_s1   <= rd_rom;
			req_s1   <= ld_hit;
			hold_s1  <= hold_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_req_q <= req_s1;
			if (write_s1)
				out_data_q <= 8'h00;
			else if (fwd_s1)
				out_data_q <= hold_s1;
			else if (rom_s1)
				out_data_q <= rom_q;
			else
				out_data_q <= ram_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_req_q, out_data_q};

	// no item taken during the clearing sweep
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("item accepted during RAM clearing");

	// a full read stage blocked by the sink must stop input
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted with both stages stalled");

	// accepted item lands in the read stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item lost before read stage");

	// a forwarded write never comes from a ROM-mapped location
	a_fwd_not_rom: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fwd_s1) |-> !rom_s1)
		else $error("write forwarded for a ROM location");

endmodule
